FILE: rtl/core/hcid_pkg.sv
package hcid_pkg;

  localparam int unsigned DefMaxFrameBytes = 1028;
  localparam int unsigned CapW             = 11;
  localparam int unsigned OffsetW          = 11;
  localparam int unsigned LenW             = 16;
  localparam int unsigned HdrW             = 3;
  localparam int unsigned ApbAddrW         = 3;
  localparam int unsigned ApbDataW         = 32;

  localparam logic [CapW-1:0] CapResetValue = CapW'(260);
  localparam logic [HdrW-1:0] HdrBytesEvent = HdrW'(2);
  localparam logic [HdrW-1:0] HdrBytesAcl   = HdrW'(4);

  localparam int unsigned EvtLenOffset   = 1;
  localparam int unsigned AclLenLoOffset = 2;
  localparam int unsigned AclLenHiOffset = 3;

  typedef enum logic [0:0] {
    RegAclMode  = 1'b0,
    RegFrameCap = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic [OffsetW-1:0] byte_offset;
    logic               frame_end;
    logic               frame_dropped;
  } out_req_t;

  typedef struct packed {
    logic            acl_mode;
    logic [CapW-1:0] frame_capacity;
  } cfg_t;

endpackage

FILE: rtl/core/hci_packet_deframer.sv
// HCI packet deframer: takes one received byte per request and returns at most one result
// per byte, one byte per cycle sustained while the output is not stalled. Each byte is
// handled by the fill counter compare and header length capture; its result lands in one
// output register, valid in the cycle after the byte is taken, and a new byte is taken
// whenever that register is empty or being drained. Bytes skipped after an overflow give
// no result. Event framing (acl_mode 0) reads the payload length from header byte 1; ACL
// framing reads a little-endian length from header bytes 2 and 3. Overflow occurs when a
// byte would sit at an offset at or beyond frame_capacity (clamped to MAX_FRAME_BYTES);
// it returns one result with frame_dropped set and discards the rest of the current chunk.
module hci_packet_deframer import hcid_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_req_t            out_data_o
);

  localparam int unsigned FillW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CmpW  = (FillW > CapW) ? FillW : CapW;
  localparam int unsigned SumW  = LenW + 1;

  cfg_t cfg;

  hcid_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  logic [FillW-1:0] fill_d, fill_q;
  logic [LenW-1:0]  plen_d, plen_q;
  logic             skip_d, skip_q;
  logic             out_valid_d, out_valid_q;
  out_req_t         out_data_d, out_data_q;

  logic             accept;
  logic [CmpW-1:0]  cap;
  logic [CmpW-1:0]  fill_ext;
  logic [FillW-1:0] fill_inc;
  logic [HdrW-1:0]  hdr;
  logic [LenW-1:0]  plen_nxt;
  logic             overflow;
  logic             done;
  logic             res_valid;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign cap = (CmpW'(cfg.frame_capacity) < CmpW'(MAX_FRAME_BYTES)) ?
               CmpW'(cfg.frame_capacity) : CmpW'(MAX_FRAME_BYTES);
  assign fill_ext = CmpW'(fill_q);
  assign overflow = fill_ext >= cap;
  assign fill_inc = fill_q + FillW'(1);
  assign hdr      = cfg.acl_mode ? HdrBytesAcl : HdrBytesEvent;

  always_comb begin
    plen_nxt = plen_q;
    if (cfg.acl_mode) begin
      if (fill_ext == CmpW'(AclLenLoOffset)) begin
        plen_nxt = LenW'(in_data_i.rx_byte);
      end else if (fill_ext == CmpW'(AclLenHiOffset)) begin
        plen_nxt = {in_data_i.rx_byte, plen_q[7:0]};
      end
    end else if (fill_ext == CmpW'(EvtLenOffset)) begin
      plen_nxt = LenW'(in_data_i.rx_byte);
    end
  end

  assign done = (SumW'(fill_inc) >= SumW'(hdr)) &&
                (SumW'(fill_inc) == (SumW'(hdr) + SumW'(plen_nxt)));

  assign res_valid = accept && !skip_q;

  always_comb begin
    fill_d     = fill_q;
    plen_d     = plen_q;
    skip_d     = skip_q;
    out_data_d = out_data_q;
    if (accept) begin
      if (skip_q) begin
        if (in_data_i.chunk_end) begin
          skip_d = 1'b0;
        end
      end else if (overflow) begin
        fill_d     = '0;
        plen_d     = '0;
        skip_d     = !in_data_i.chunk_end;
        out_data_d = '0;
        out_data_d.frame_dropped = 1'b1;
      end else begin
        plen_d                   = plen_nxt;
        fill_d                   = done ? '0 : fill_inc;
        out_data_d.out_byte      = in_data_i.rx_byte;
        out_data_d.byte_offset   = fill_ext[OffsetW-1:0];
        out_data_d.frame_end     = done;
        out_data_d.frame_dropped = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      plen_q      <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      plen_q      <= plen_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/core/hcid_cfg_regs.sv
module hcid_cfg_regs import hcid_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_d, cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegAclMode:  cfg_d.acl_mode       = pwdata[0];
        RegFrameCap: cfg_d.frame_capacity = pwdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegAclMode:  prdata = {{(ApbDataW-1){1'b0}}, cfg_q.acl_mode};
      RegFrameCap: prdata = {{(ApbDataW-CapW){1'b0}}, cfg_q.frame_capacity};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.acl_mode       <= 1'b0;
      cfg_q.frame_capacity <= CapResetValue;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/hcid_checker.sv
module hcid_checker import hcid_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input out_req_t            out_data_o
);

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output register free");

  a_drop_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_dropped) |->
      (out_data_o.out_byte == 8'd0 && out_data_o.byte_offset == '0 &&
       !out_data_o.frame_end))
    else $error("dropped result carries payload");

  a_drop_end_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.frame_end && out_data_o.frame_dropped))
    else $error("result both ends and drops frame");

  a_after_end_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.frame_end) ##1
      (out_valid_o && !out_data_o.frame_dropped) |-> (out_data_o.byte_offset == '0))
    else $error("frame after completed frame does not start at offset zero");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind hci_packet_deframer hcid_checker u_hcid_checker (.*);

FILE: tb/tb_hci_packet_deframer.sv
module tb_hci_packet_deframer;

  timeunit 1ns;
  timeprecision 1ps;

  import hcid_pkg::*;

  localparam int unsigned MaxBytes   = DefMaxFrameBytes;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned SettleCyc  = 4;
  localparam int unsigned PrintCap   = 40;

  typedef struct packed {
    logic [OffsetW-1:0] fill;
    logic [LenW-1:0]    plen;
    logic               skip;
  } frame_st_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_req_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_req_t            out_data_o;

  hci_packet_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  in_req_t         byte_q[$];
  out_req_t        framed_q[$];
  frame_st_t       parse_st       = '0;
  logic            cfg_acl        = 1'b0;
  logic [CapW-1:0] cfg_cap        = CapResetValue;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  logic            hold_go        = 1'b0;
  int unsigned     hold_left      = 0;
  int unsigned     cycle_cnt      = 0;
  int unsigned     err_cnt        = 0;
  int unsigned     n_bytes        = 0;
  int unsigned     n_results      = 0;
  int unsigned     n_frames       = 0;
  int unsigned     n_drops        = 0;
  out_req_t        pred_res;
  out_req_t        want_res;

  function automatic bit deframe_step(inout frame_st_t st, input logic acl,
                                      input logic [CapW-1:0] cap_reg, input in_req_t req,
                                      output out_req_t res);
    int unsigned hdr;
    int unsigned cap;
    int unsigned offs;
    res = '0;
    hdr = acl ? HdrBytesAcl : HdrBytesEvent;
    cap = (cap_reg < MaxBytes) ? cap_reg : MaxBytes;
    if (st.skip) begin
      if (req.chunk_end) st.skip = 1'b0;
      return 1'b0;
    end
    if (st.fill >= cap) begin
      st.fill = '0;
      st.plen = '0;
      st.skip = !req.chunk_end;
      res.frame_dropped = 1'b1;
      return 1'b1;
    end
    offs = st.fill;
    if (acl) begin
      if (offs == AclLenLoOffset) st.plen = {8'h00, req.rx_byte};
      else if (offs == AclLenHiOffset) st.plen = {req.rx_byte, st.plen[7:0]};
    end else if (offs == EvtLenOffset) begin
      st.plen = {8'h00, req.rx_byte};
    end
    st.fill = OffsetW'(offs + 1);
    res.out_byte    = req.rx_byte;
    res.byte_offset = OffsetW'(offs);
    if (offs + 1 >= hdr && offs + 1 == hdr + st.plen) begin
      res.frame_end = 1'b1;
      st.fill = '0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_cnt < PrintCap) $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      n_bytes++;
      if (deframe_step(parse_st, cfg_acl, cfg_cap, in_data_i, pred_res))
        framed_q.push_back(pred_res);
    end
    if (!in_valid_i || !in_stall_o) begin
      if (rst_ni && byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data_i  <= byte_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_go) hold_left <= LongHold;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (out_data_o.frame_end) n_frames++;
      if (out_data_o.frame_dropped) n_drops++;
      if (framed_q.size() == 0) begin
        report_mismatch($sformatf("result %p with no request pending", out_data_o));
      end else begin
        want_res = framed_q.pop_front();
        if (out_data_o.out_byte !== want_res.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h",
                                    out_data_o.out_byte, want_res.out_byte));
        if (out_data_o.byte_offset !== want_res.byte_offset)
          report_mismatch($sformatf("byte_offset %0d, want %0d",
                                    out_data_o.byte_offset, want_res.byte_offset));
        if (out_data_o.frame_end !== want_res.frame_end)
          report_mismatch($sformatf("frame_end %b, want %b",
                                    out_data_o.frame_end, want_res.frame_end));
        if (out_data_o.frame_dropped !== want_res.frame_dropped)
          report_mismatch($sformatf("frame_dropped %b, want %b",
                                    out_data_o.frame_dropped, want_res.frame_dropped));
      end
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
               framed_q.size());
      $display("tb_hci_packet_deframer: done, errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] v, input logic ce);
    in_req_t b;
    b.rx_byte   = v;
    b.chunk_end = ce;
    byte_q.push_back(b);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || in_valid_i || framed_q.size() != 0);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegAclMode:  cfg_acl = val[0];
      RegFrameCap: cfg_cap = val[CapW-1:0];
      default: ;
    endcase
  endtask

  // mostly well-formed frames with random content, tracked on a private copy of the parser
  task automatic gen_bytes(input int count);
    frame_st_t   sh;
    out_req_t    r;
    in_req_t     b;
    logic [15:0] want_len;
    int unsigned offs;
    sh       = parse_st;
    want_len = '0;
    repeat (count) begin
      b.rx_byte   = 8'($urandom);
      b.chunk_end = ($urandom_range(0, 99) < 12);
      if (sh.skip) begin
        b.chunk_end = ($urandom_range(0, 1) == 1);
      end else if ($urandom_range(0, 99) >= 5) begin
        offs = sh.fill;
        if (offs == 0) begin
          case ($urandom_range(0, 15))
            0:       want_len = 16'($urandom_range(61, cfg_acl ? 1100 : 255));
            1, 2:    want_len = 16'($urandom_range(9, 60));
            default: want_len = 16'($urandom_range(0, 8));
          endcase
        end
        if (cfg_acl && offs == AclLenLoOffset) b.rx_byte = want_len[7:0];
        else if (cfg_acl && offs == AclLenHiOffset) b.rx_byte = want_len[15:8];
        else if (!cfg_acl && offs == EvtLenOffset) b.rx_byte = want_len[7:0];
      end
      void'(deframe_step(sh, cfg_acl, cfg_cap, b, r));
      byte_q.push_back(b);
    end
  endtask

  task automatic run_phase(input logic acl, input logic [CapW-1:0] cap,
                           input int unsigned idle_pct, input int unsigned stall_pct,
                           input int count);
    wait_idle();
    apb_write(RegAclMode, ApbDataW'(acl));
    apb_write(RegFrameCap, ApbDataW'(cap));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    gen_bytes(count);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty event frame, then leave a frame open across a mode switch
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h05, 1'b0);
    wait_idle();
    apb_write(RegAclMode, ApbDataW'(1'b1));
    apb_write(RegFrameCap, ApbDataW'(5));
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h9c, 1'b0);
    // overflow mid-chunk, then drop bytes up to the chunk end
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'h88, 1'b1);
    // overflow on the chunk end itself
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hab, 1'b0);
    push_byte(8'hcd, 1'b1);
    // empty ACL frame whose first two header bytes are all ones
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);

    run_phase(1'b0, 11'd260,  0,  0,  150);
    run_phase(1'b1, 11'd1028, 71, 0,  150);
    run_phase(1'b1, 11'd5,    0,  71, 150);
    run_phase(1'b0, 11'd2047, 9,  9,  150);
    // stall the output long enough to back up the input
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    run_phase(1'b1, 11'd0,    0,  0,  100);
    run_phase(1'b0, 11'd64,   0,  71, 75);
    // pause the sender until every result is out
    wait_idle();
    gen_bytes(75);
    run_phase(1'b1, 11'd300,  9,  9,  200);
    run_phase(1'b0, 11'd255,  71, 71, 100);
    wait_idle();

    $display("covered %0d bytes over event and ACL framing, capacities 0 to 2047, with idling",
             n_bytes);
    $display("checked %0d results: %0d frames closed, %0d overflow drops",
             n_results, n_frames, n_drops);
    if (err_cnt == 0) begin
      $display("tb_hci_packet_deframer: done, clean");
    end else begin
      $display("tb_hci_packet_deframer: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/hcid_pkg.sv
rtl/core/hcid_cfg_regs.sv
rtl/core/hci_packet_deframer.sv
rtl/core/hcid_checker.sv
tb/tb_hci_packet_deframer.sv
